>>> rtl/core/irrgb_pkg.sv
// shared types, command codes and helpers for the infrared remote rgb dimmer
package irrgb_pkg;

  // remote command bytes
  localparam logic [7:0] CMD_OFF   = 8'h47;
  localparam logic [7:0] CMD_ON    = 8'h45;
  localparam logic [7:0] CMD_RED   = 8'h44;
  localparam logic [7:0] CMD_GREEN = 8'h40;
  localparam logic [7:0] CMD_BLUE  = 8'h43;
  localparam logic [7:0] CMD_UP    = 8'h4A;
  localparam logic [7:0] CMD_DOWN  = 8'h52;
  localparam logic [7:0] CMD_RESET = 8'h42;

  // brightness limits
  localparam logic [3:0] LEVEL_MAX = 4'd8;
  localparam logic [3:0] LEVEL_ON  = 4'd4;

  // register reset values
  localparam logic [31:0] WINDOW_DEFAULT = 32'd300000;
  localparam logic [7:0]  BASE_R_RESET   = 8'd255;
  localparam logic [7:0]  BASE_G_RESET   = 8'd80;
  localparam logic [7:0]  BASE_B_RESET   = 8'd20;

  // configuration register indexes
  localparam logic REG_RING_PRESENT = 1'b0;
  localparam logic REG_REPEAT_WINDOW = 1'b1;

  localparam int ADDR_W = 3;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_HANDLED    = 2'd0,
    STATUS_DUPLICATE  = 2'd1,
    STATUS_UNASSIGNED = 2'd2,
    STATUS_NO_RING    = 2'd3
  } status_t;

  // input transaction
  typedef struct packed {
    logic [7:0]  command_code;
    logic [62:0] time_us;
  } cmd_t;

  // result transaction
  typedef struct packed {
    status_t    status;
    logic       light_update;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       prompt_trigger;
  } rsp_t;

  // channel value times level, divided by eight
  function automatic logic [7:0] scale(input logic [7:0] base, input logic [3:0] level);
    logic [11:0] prod;
    prod = {4'd0, base} * {8'd0, level};
    return prod[10:3];
  endfunction

endpackage

>>> rtl/core/ir_remote_rgb_dimmer_top.sv
// infrared remote rgb dimmer: duplicate filter, lamp state and color scaling
//
//  channel  | direction | handshake          | payload
//  cmd      | in        | cmd_valid/cmd_stall | command_code, time_us
//  rsp      | out       | rsp_valid/rsp_stall | status, light_update, colors, prompt_trigger
//  apb      | in/out    | psel/penable/pready | ring_present, repeat_window_us
//
// the command is decoded, the state updated and the result registered at the
// accepting edge; a new command every cycle while cmd_stall is low.
// the result register frees as its result is taken, so cmd_stall only rises
// while a result waits under rsp_stall.
// synchronous reset returns the lamp state, the repeat filter and the registers to their reset values.
module ir_remote_rgb_dimmer_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  irrgb_pkg::cmd_t              cmd,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output irrgb_pkg::rsp_t              rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [irrgb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import irrgb_pkg::*;

  // configuration registers
  logic        ring_present;
  logic [31:0] repeat_window_us;

  // command state
  logic [7:0]  last_code, last_code_next;
  logic [62:0] last_time, last_time_next;
  logic        lamp_on, lamp_on_next;
  logic [3:0]  bright_level, bright_level_next;
  logic [7:0]  base_r, base_r_next;
  logic [7:0]  base_g, base_g_next;
  logic [7:0]  base_b, base_b_next;

  logic        accept;
  logic        dup;
  logic        emit;
  logic [62:0] elapsed;
  rsp_t        rsp_next;

  assign pready    = 1'b1;
  assign cmd_stall = rsp_valid & rsp_stall;
  assign accept    = cmd_valid & ~cmd_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_present     <= 1'b1;
      repeat_window_us <= WINDOW_DEFAULT;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_RING_PRESENT:  ring_present     <= pwdata[0];
        REG_REPEAT_WINDOW: repeat_window_us <= pwdata;
        default: ;
      endcase
    end
  end

  // configuration reads
  always_comb begin
    unique case (paddr[2])
      REG_RING_PRESENT:  prdata = {31'd0, ring_present};
      REG_REPEAT_WINDOW: prdata = repeat_window_us;
      default:           prdata = 32'd0;
    endcase
  end

  // repeat filter
  assign elapsed = cmd.time_us - last_time;
  assign dup = (cmd.command_code == last_code) &&
               ((cmd.time_us < last_time) || (elapsed < {31'd0, repeat_window_us}));

  // command decode and next state
  always_comb begin
    last_code_next    = last_code;
    last_time_next    = last_time;
    lamp_on_next      = lamp_on;
    bright_level_next = bright_level;
    base_r_next       = base_r;
    base_g_next       = base_g;
    base_b_next       = base_b;
    emit              = 1'b0;
    rsp_next          = '0;
    rsp_next.status   = STATUS_HANDLED;
    if (dup) begin
      rsp_next.status = STATUS_DUPLICATE;
    end else begin
      last_code_next = cmd.command_code;
      last_time_next = cmd.time_us;
      if (!ring_present) begin
        if (cmd.command_code == CMD_RESET) begin
          rsp_next.prompt_trigger = 1'b1;
        end else begin
          rsp_next.status = STATUS_NO_RING;
        end
      end else begin
        unique case (cmd.command_code)
          CMD_OFF: begin
            lamp_on_next = 1'b0;
            emit         = 1'b1;
          end
          CMD_ON: begin
            if (bright_level == 4'd0) bright_level_next = LEVEL_ON;
            lamp_on_next = 1'b1;
            emit         = 1'b1;
          end
          CMD_RED: begin
            base_r_next  = 8'd255;
            base_g_next  = 8'd0;
            base_b_next  = 8'd0;
            lamp_on_next = 1'b1;
            emit         = 1'b1;
          end
          CMD_GREEN: begin
            base_r_next  = 8'd0;
            base_g_next  = 8'd255;
            base_b_next  = 8'd0;
            lamp_on_next = 1'b1;
            emit         = 1'b1;
          end
          CMD_BLUE: begin
            base_r_next  = 8'd0;
            base_g_next  = 8'd0;
            base_b_next  = 8'd255;
            lamp_on_next = 1'b1;
            emit         = 1'b1;
          end
          CMD_UP: begin
            if (bright_level < LEVEL_MAX) bright_level_next = bright_level + 4'd1;
            lamp_on_next = 1'b1;
            emit         = 1'b1;
          end
          CMD_DOWN: begin
            if (bright_level != 4'd0) bright_level_next = bright_level - 4'd1;
            if (bright_level <= 4'd1) lamp_on_next = 1'b0;
            emit = 1'b1;
          end
          CMD_RESET: begin
            rsp_next.prompt_trigger = 1'b1;
          end
          default: begin
            rsp_next.status = STATUS_UNASSIGNED;
          end
        endcase
      end
    end
    // ring color from the updated state, black when off or at level zero
    rsp_next.light_update = emit;
    if (emit && lamp_on_next && (bright_level_next != 4'd0)) begin
      rsp_next.red_out   = scale(base_r_next, bright_level_next);
      rsp_next.green_out = scale(base_g_next, bright_level_next);
      rsp_next.blue_out  = scale(base_b_next, bright_level_next);
    end
  end

  // state update on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      last_code    <= 8'd0;
      last_time    <= 63'd0;
      lamp_on      <= 1'b0;
      bright_level <= LEVEL_ON;
      base_r       <= BASE_R_RESET;
      base_g       <= BASE_G_RESET;
      base_b       <= BASE_B_RESET;
    end else if (accept) begin
      last_code    <= last_code_next;
      last_time    <= last_time_next;
      lamp_on      <= lamp_on_next;
      bright_level <= bright_level_next;
      base_r       <= base_r_next;
      base_g       <= base_g_next;
      base_b       <= base_b_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> verif/tb_ir_remote_rgb_dimmer_top.sv
// testbench for the infrared remote rgb dimmer: directed and random commands, scoreboard check
module tb_ir_remote_rgb_dimmer_top;
  import irrgb_pkg::*;

  // register byte addresses
  localparam logic [ADDR_W-1:0] ADDR_RING   = {REG_RING_PRESENT, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_WINDOW = {REG_REPEAT_WINDOW, 2'b00};
  localparam logic [62:0]       TIME_MAX    = {63{1'b1}};

  // tracks lamp state and checks each response against the predicted one
  class dimmer_scoreboard;
    logic [7:0]  last_code;
    logic [63:0] last_time;
    bit          lamp_on;
    logic [3:0]  level;
    logic [7:0]  base_r, base_g, base_b;
    bit          ring_present;
    logic [31:0] window_us;
    rsp_t        pending_responses[$];
    int errors, commands, duplicates, light_updates, prompts, no_ring, unassigned;

    function new();
      last_code    = 8'd0;
      last_time    = 64'd0;
      lamp_on      = 1'b0;
      level        = LEVEL_ON;
      base_r       = BASE_R_RESET;
      base_g       = BASE_G_RESET;
      base_b       = BASE_B_RESET;
      ring_present = 1'b1;
      window_us    = WINDOW_DEFAULT;
    endfunction

    function int pending();
      return pending_responses.size();
    endfunction

    task report_mismatch(input string what);
      errors++;
      $display("[%0t] mismatch %0d: %s", $realtime, errors, what);
    endtask

    // channel times level over eight, truncated
    function logic [7:0] dim_channel(input logic [7:0] b);
      int unsigned p;
      p = int'(b) * int'(level);
      return 8'(p / 8);
    endfunction

    // ring rewrite, black while off or at level zero
    function rsp_t ring_color(input rsp_t r);
      r.light_update = 1'b1;
      if (lamp_on && level != 4'd0) begin
        r.red_out   = dim_channel(base_r);
        r.green_out = dim_channel(base_g);
        r.blue_out  = dim_channel(base_b);
      end
      return r;
    endfunction

    // repeat filter, then lamp state update for one command
    function rsp_t predict_response(input cmd_t c);
      rsp_t        r;
      logic [63:0] now;
      r = '0;
      r.status = STATUS_HANDLED;
      now = {1'b0, c.time_us};
      if (c.command_code == last_code &&
          (now < last_time || (now - last_time) < {32'd0, window_us})) begin
        r.status = STATUS_DUPLICATE;
        return r;
      end
      last_code = c.command_code;
      last_time = now;
      if (!ring_present) begin
        if (c.command_code == CMD_RESET) r.prompt_trigger = 1'b1;
        else r.status = STATUS_NO_RING;
        return r;
      end
      case (c.command_code)
        CMD_OFF: begin
          lamp_on = 1'b0;
          r = ring_color(r);
        end
        CMD_ON: begin
          if (level == 4'd0) level = LEVEL_ON;
          lamp_on = 1'b1;
          r = ring_color(r);
        end
        CMD_RED: begin
          base_r = 8'd255; base_g = 8'd0; base_b = 8'd0;
          lamp_on = 1'b1;
          r = ring_color(r);
        end
        CMD_GREEN: begin
          base_r = 8'd0; base_g = 8'd255; base_b = 8'd0;
          lamp_on = 1'b1;
          r = ring_color(r);
        end
        CMD_BLUE: begin
          base_r = 8'd0; base_g = 8'd0; base_b = 8'd255;
          lamp_on = 1'b1;
          r = ring_color(r);
        end
        CMD_UP: begin
          if (level < LEVEL_MAX) level = level + 4'd1;
          lamp_on = 1'b1;
          r = ring_color(r);
        end
        CMD_DOWN: begin
          if (level != 4'd0) level = level - 4'd1;
          if (level == 4'd0) lamp_on = 1'b0;
          r = ring_color(r);
        end
        CMD_RESET: r.prompt_trigger = 1'b1;
        default: r.status = STATUS_UNASSIGNED;
      endcase
      return r;
    endfunction

    function void note_command(input cmd_t c);
      commands++;
      pending_responses.push_back(predict_response(c));
    endfunction

    // compare one accepted response with the oldest prediction
    task check_response(input rsp_t got);
      rsp_t want;
      if (pending_responses.size() == 0) begin
        report_mismatch($sformatf("response with none expected: %h", got));
        return;
      end
      want = pending_responses.pop_front();
      if (got.status != want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.light_update != want.light_update)
        report_mismatch($sformatf("light_update got %0b want %0b",
                                  got.light_update, want.light_update));
      if (got.red_out != want.red_out)
        report_mismatch($sformatf("red_out got %0d want %0d", got.red_out, want.red_out));
      if (got.green_out != want.green_out)
        report_mismatch($sformatf("green_out got %0d want %0d",
                                  got.green_out, want.green_out));
      if (got.blue_out != want.blue_out)
        report_mismatch($sformatf("blue_out got %0d want %0d", got.blue_out, want.blue_out));
      if (got.prompt_trigger != want.prompt_trigger)
        report_mismatch($sformatf("prompt_trigger got %0b want %0b",
                                  got.prompt_trigger, want.prompt_trigger));
      if (want.status == STATUS_DUPLICATE) duplicates++;
      if (want.status == STATUS_NO_RING) no_ring++;
      if (want.status == STATUS_UNASSIGNED) unassigned++;
      if (want.light_update) light_updates++;
      if (want.prompt_trigger) prompts++;
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              cmd_valid;
  logic              cmd_stall;
  cmd_t              cmd;
  logic              rsp_valid;
  logic              rsp_stall;
  rsp_t              rsp;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  dimmer_scoreboard sb = new();
  bit          calm;
  int          stall_left;
  int          settings;
  logic [62:0] clock_us;
  logic [7:0]  last_sent;

  ir_remote_rgb_dimmer_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // present one command and hold it until accepted
  task automatic push_command(input logic [7:0] code, input logic [62:0] t);
    cmd_t c;
    c.command_code = code;
    c.time_us      = t;
    @(negedge clk);
    cmd_valid = 1'b1;
    cmd       = c;
    do @(posedge clk); while (cmd_stall);
    sb.note_command(c);
    last_sent = code;
  endtask

  // idle cycles between commands, mostly short
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  task automatic idle_sender(input int n);
    if (n > 0) begin
      @(negedge clk);
      cmd_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // hold off new commands until every response is back
  task automatic drain_responses();
    @(negedge clk);
    cmd_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // register write followed by a readback
  task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [31:0] data,
                                input logic [31:0] mask);
    logic [31:0] got;
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable = 1'b0; pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
    if ((got & mask) != (data & mask))
      sb.report_mismatch($sformatf("register %0d reads %h want %h", addr, got & mask,
                                   data & mask));
    if (addr == ADDR_RING) sb.ring_present = data[0];
    else sb.window_us = data;
    settings++;
  endtask

  // light commands by index
  function automatic logic [7:0] light_command(input int i);
    case (i)
      0: return CMD_OFF;
      1: return CMD_ON;
      2: return CMD_RED;
      3: return CMD_GREEN;
      4: return CMD_BLUE;
      5: return CMD_UP;
      6: return CMD_DOWN;
      default: return CMD_RESET;
    endcase
  endfunction

  // command stream with repeats and time steps around the window
  task automatic run_random(input int n);
    int          r;
    logic [7:0]  code;
    logic [63:0] step;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) code = last_sent;
      else if (r < 85) code = light_command($urandom_range(0, 7));
      else code = 8'($urandom);
      r = $urandom_range(0, 99);
      if (r < 40) begin
        clock_us = clock_us + 63'($urandom_range(0, 2000));
      end else if (r < 75) begin
        step = {32'd0, sb.window_us} + 64'($urandom_range(0, 4)) - 64'd2;
        clock_us = clock_us + step[62:0];
      end else if (r < 90) begin
        clock_us = clock_us + {31'd0, 32'($urandom)};
      end else if (r < 96) begin
        clock_us = 63'({$urandom, $urandom});
      end else begin
        clock_us = clock_us - 63'($urandom_range(1, 1000));
      end
      push_command(code, clock_us);
      idle_sender(idle_cycles());
    end
  endtask

  // response side stall pattern
  initial begin
    int r;
    rsp_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (calm) begin
        rsp_stall = 1'b0;
      end else if (stall_left > 0) begin
        rsp_stall = 1'b1;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          rsp_stall = 1'b0;
        end else begin
          rsp_stall  = 1'b1;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 60);
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  // run limit
  initial begin
    #8000000;
    $display("FAIL ir_remote_rgb_dimmer_top");
    $finish;
  end

  // stimulus
  initial begin
    logic [62:0] t;
    logic        ring;
    logic [31:0] win;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    calm      = 1'b0;
    settings  = 0;
    clock_us  = '0;
    last_sent = 8'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: code zero right after reset is a repeat of the cleared code
    push_command(8'h00, 63'd0);
    push_command(CMD_ON, 63'd10);
    t = 63'd300010;
    push_command(CMD_UP, t);
    // one short of the window, then exactly the window
    push_command(CMD_UP, t + 63'd299999);
    for (int i = 0; i < 4; i++) begin
      t = t + 63'd300000;
      push_command(CMD_UP, t);
    end
    t = t + 63'd1;
    push_command(CMD_RED, t);
    push_command(CMD_GREEN, t + 63'd1);
    push_command(CMD_BLUE, t + 63'd2);
    t = t + 63'd3;
    // dim all the way down and past zero
    for (int i = 0; i < 9; i++) begin
      push_command(CMD_DOWN, t);
      t = t + 63'd300000;
    end
    // color at level zero lights up black, on restores the middle level
    push_command(CMD_BLUE, t);
    push_command(CMD_ON, t + 63'd1);
    push_command(CMD_OFF, t + 63'd2);
    push_command(CMD_RESET, t + 63'd3);
    push_command(8'hFF, t + 63'd4);
    // same code with time running backwards
    push_command(8'hFF, t);
    push_command(8'h00, TIME_MAX);
    clock_us = t + 63'd10;

    // random phases, each under its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      drain_responses();
      case (ph)
        0: begin ring = 1'b1; win = WINDOW_DEFAULT; end
        1: begin ring = 1'b1; win = 32'd0; end
        2: begin ring = 1'b1; win = 32'hFFFF_FFFF; end
        3: begin ring = 1'b0; win = 32'd1000; end
        4: begin ring = 1'b1; win = 32'd50; end
        5: begin ring = 1'b0; win = 32'd0; end
        6: begin ring = 1'b0; win = 32'hFFFF_FFFF; end
        default: begin ring = 1'b1; win = $urandom_range(1, 100000); end
      endcase
      write_register(ADDR_WINDOW, win, 32'hFFFF_FFFF);
      write_register(ADDR_RING, {31'd0, ring}, 32'd1);
      calm = (ph == 2 || ph == 5);
      run_random(160);
    end

    drain_responses();
    repeat (5) @(posedge clk);
    $display("covered %0d commands: %0d duplicates, %0d light updates, %0d prompts",
             sb.commands, sb.duplicates, sb.light_updates, sb.prompts);
    $display("%0d register writes, %0d ignored without ring, %0d unassigned codes",
             settings, sb.no_ring, sb.unassigned);
    if (sb.errors == 0) begin
      $display("PASS ir_remote_rgb_dimmer_top");
    end else begin
      $display("FAIL ir_remote_rgb_dimmer_top");
    end
    $finish;
  end

endmodule
